// ===== rtl/kci_pkg.sv =====
// Shared constants, codes and control types of the keyframe curve interpolator.
package kci_pkg;

    localparam int MAX_KEYS   = 16;
    localparam int KEY_IDX_W  = 4;
    localparam int COUNT_W    = 5;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int STEP_W     = 6;

    localparam logic [COUNT_W-1:0] MAX_KEYS_C = COUNT_W'(MAX_KEYS);

    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_EVAL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 1'd1;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CUBIC  = 2'd1;

    localparam logic [STEP_W-1:0] MOD_STEPS    = 6'd32;
    localparam logic [STEP_W-1:0] LINEAR_STEPS = 6'd48;
    localparam logic [STEP_W-1:0] CUBIC_STEPS  = 6'd49;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WRITE,
        OP_QUERY,
        OP_MOD,
        OP_MOD_END,
        OP_SCAN,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_PREP,
        OP_FRAC,
        OP_FRAC_END,
        OP_CUBE1,
        OP_CUBE2,
        OP_MUL,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                 op;
        logic [KEY_IDX_W-1:0]   idx;
        logic [MODE_W-1:0]      mode;
        logic                   empty;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic kt_le;
        logic kt_ge;
        logic interp_ok;
    } dp_stat_t;

endpackage

// ===== rtl/kci_if.sv =====
// Handshake channels of the keyframe curve interpolator.
interface kci_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [3:0]  key_index;
    logic [31:0] sample_time;
    logic signed [31:0] key_value;

    modport source (output valid, opcode, key_index, sample_time, key_value, input ready);
    modport sink   (input valid, opcode, key_index, sample_time, key_value, output ready);
endinterface

interface kci_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] curve_value;
    logic        table_empty;

    modport source (output valid, curve_value, table_empty, input ready);
    modport sink   (input valid, curve_value, table_empty, output ready);
endinterface

interface kci_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [4:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/keyframe_curve_interpolator.sv =====
// Keyframe curve interpolator top level: controller plus datapath.
// Write beats are taken in idle and written straight to the key table. An evaluation on an empty
// table goes straight to the result; else it runs the wrap on the shared bit-serial divider, the
// key scan, load and prepare, then posts the result once the response channel is free. Linear adds
// a division and a multiply, cubic a division, the ease and a multiply; next beat taken once posted.
// Reset clears controller, configuration and divider control; key table and datapath data registers are not reset.
module keyframe_curve_interpolator (
    input  logic clk,
    input  logic rst_n,
    kci_req_if.sink   req,
    kci_rsp_if.source rsp,
    kci_cfg_if.sink   cfg
);
    import kci_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kci_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .cfg_valid  (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .cfg_ready  (cfg.ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    kci_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .key_index   (req.key_index),
        .sample_time (req.sample_time),
        .key_value   (req.key_value),
        .curve_value (rsp.curve_value),
        .table_empty (rsp.table_empty)
    );
endmodule

// ===== rtl/kci_div.sv =====
// Restoring divider, one quotient bit per cycle, giving remainder and quotient.
module kci_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [32:0] divisor,
    input  logic [kci_pkg::STEP_W-1:0] steps,
    output logic        done,
    output logic [32:0] rem,
    output logic [17:0] quo
);
    import kci_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [48:0]       dvd_reg;
    logic [32:0]       div_reg;
    logic [32:0]       rem_reg;
    logic [17:0]       quo_reg;
    logic [33:0]       trial;
    logic              ge;
    logic [32:0]       rem_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[48]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? 33'(trial - {1'b0, div_reg}) : trial[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {dividend, 17'd0};
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[47:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[16:0], ge};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;
endmodule

// ===== rtl/kci_dp.sv =====
// Datapath: key table, wrap, fraction division, cubic ease and result register.
module kci_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  kci_pkg::dp_cmd_t   cmd,
    output kci_pkg::dp_stat_t  stat,
    input  logic [3:0]         key_index,
    input  logic [31:0]        sample_time,
    input  logic signed [31:0] key_value,
    output logic signed [31:0] curve_value,
    output logic               table_empty
);
    import kci_pkg::*;

    logic [31:0]        kt_mem [MAX_KEYS];
    logic signed [31:0] kv_mem [MAX_KEYS];

    logic [31:0]        query_reg;
    logic [31:0]        t_reg;
    logic [31:0]        ka_reg;
    logic [31:0]        kb_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic [31:0]        span_reg;
    logic [31:0]        dt_reg;
    logic signed [32:0] diff_reg;
    logic               ok_reg;
    logic [17:0]        f_reg;
    logic [16:0]        x_reg;
    logic [32:0]        sq_reg;
    logic [17:0]        q_reg;
    logic signed [51:0] prod_reg;
    logic signed [31:0] curve_reg;
    logic               empty_reg;

    logic [31:0]        kt_rd;
    logic signed [31:0] kv_rd;
    logic               ok_comb;
    logic [31:0]        dt_raw;
    logic               div_start;
    logic [31:0]        div_dvd;
    logic [32:0]        div_dsr;
    logic [STEP_W-1:0]  div_steps;
    logic [32:0]        div_rem;
    logic [17:0]        div_quo;
    logic               div_done;
    logic               lin;
    logic [16:0]        x_next;
    logic [33:0]        cube_full;
    logic [17:0]        cube;
    logic [17:0]        frac;
    logic signed [51:0] adj;
    logic signed [35:0] shifted;
    logic signed [36:0] sum;
    logic signed [31:0] sat;

    kci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .steps    (div_steps),
        .done     (div_done),
        .rem      (div_rem),
        .quo      (div_quo)
    );

    always_comb
    begin
        kt_rd     = kt_mem[cmd.idx];
        kv_rd     = kv_mem[cmd.idx];
        lin       = cmd.mode == MODE_LINEAR;
        ok_comb   = (lo_reg != hi_reg)
                    && (cmd.mode == MODE_LINEAR || cmd.mode == MODE_CUBIC)
                    && (kb_reg > ka_reg) && (t_reg >= ka_reg);
        dt_raw    = t_reg - ka_reg;
        div_start = (cmd.op == OP_MOD) || (cmd.op == OP_FRAC);
        if (cmd.op == OP_MOD)
        begin
            div_dvd   = query_reg;
            div_dsr   = {1'b0, kt_rd} + 33'h10000;
            div_steps = MOD_STEPS;
        end
        else
        begin
            div_dvd   = dt_reg;
            div_dsr   = {1'b0, span_reg};
            div_steps = lin ? LINEAR_STEPS : CUBIC_STEPS;
        end
        x_next    = f_reg[17:16] == 2'b00 ? f_reg[16:0] : 17'(18'h20000 - f_reg);
        cube_full = sq_reg[32:16] * x_reg;
        cube      = cube_full[33:16];
        frac      = lin ? f_reg : q_reg;
        adj       = prod_reg + ((prod_reg < 0) ? (lin ? 52'sd65535 : 52'sd131071) : 52'sd0);
        shifted   = lin ? 36'(adj >>> 16) : 36'(adj >>> 17);
        sum       = 37'(shifted) + 37'(lo_reg);
        if (sum > 37'sd2147483647)
            sat = 32'sh7fffffff;
        else if (sum < -37'sd2147483648)
            sat = 32'sh80000000;
        else
            sat = sum[31:0];

        stat.div_done  = div_done;
        stat.kt_le     = kt_rd <= t_reg;
        stat.kt_ge     = kt_rd >= t_reg;
        stat.interp_ok = ok_comb;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_WRITE:
            begin
                kt_mem[key_index] <= sample_time;
                kv_mem[key_index] <= key_value;
            end
            OP_QUERY:    query_reg <= sample_time;
            OP_MOD_END:  t_reg <= div_rem[31:0];
            OP_LOAD_A:
            begin
                ka_reg <= kt_rd;
                lo_reg <= kv_rd;
            end
            OP_LOAD_B:
            begin
                kb_reg <= kt_rd;
                hi_reg <= kv_rd;
            end
            OP_PREP:
            begin
                ok_reg   <= ok_comb;
                span_reg <= kb_reg - ka_reg;
                dt_reg   <= (dt_raw > kb_reg - ka_reg) ? kb_reg - ka_reg : dt_raw;
                diff_reg <= 33'(hi_reg) - 33'(lo_reg);
            end
            OP_FRAC_END: f_reg <= div_quo;
            OP_CUBE1:
            begin
                x_reg  <= x_next;
                sq_reg <= x_next * x_next;
            end
            OP_CUBE2:    q_reg <= f_reg[17:16] == 2'b00 ? cube : 18'(18'h20000 - cube);
            OP_MUL:      prod_reg <= diff_reg * $signed({1'b0, frac});
            OP_RESULT:
            begin
                empty_reg <= cmd.empty;
                if (cmd.empty)
                    curve_reg <= '0;
                else if (ok_reg)
                    curve_reg <= sat;
                else
                    curve_reg <= lo_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign curve_value = curve_reg;
    assign table_empty = empty_reg;
endmodule

// ===== rtl/kci_ctrl.sv =====
// Controller: handshakes, configuration registers and evaluation sequencing.
module kci_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_opcode,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  logic              cfg_valid,
    input  logic [kci_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kci_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic              cfg_ready,
    output kci_pkg::dp_cmd_t  cmd,
    input  kci_pkg::dp_stat_t stat
);
    import kci_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_MOD_WAIT,
        S_SCAN,
        S_LOAD_A,
        S_LOAD_B,
        S_PREP,
        S_FRAC,
        S_FRAC_WAIT,
        S_CUBE1,
        S_CUBE2,
        S_MUL,
        S_FINISH
    } state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [COUNT_W-1:0]   n_reg;
    logic [KEY_IDX_W-1:0] i_reg;
    logic [KEY_IDX_W-1:0] a_reg;
    logic [KEY_IDX_W-1:0] b_reg;
    logic                 empty_reg;
    logic                 out_valid_reg;

    logic [COUNT_W-1:0]   n_clamp;
    logic [KEY_IDX_W-1:0] last_idx;
    logic                 take;
    logic                 out_free;

    always_comb
    begin
        n_clamp  = (count_reg > MAX_KEYS_C) ? MAX_KEYS_C : count_reg;
        last_idx = KEY_IDX_W'(n_reg - 1'b1);
        take     = req_valid && state_reg == S_IDLE;
        out_free = !out_valid_reg || rsp_ready;

        cmd.op    = OP_NONE;
        cmd.idx   = '0;
        cmd.mode  = mode_reg;
        cmd.empty = empty_reg;
        unique case (state_reg)
            S_IDLE:      if (take) cmd.op = (req_opcode == OPC_WRITE) ? OP_WRITE : OP_QUERY;
            S_MOD:
            begin
                cmd.op  = OP_MOD;
                cmd.idx = last_idx;
            end
            S_MOD_WAIT:  if (stat.div_done) cmd.op = OP_MOD_END;
            S_SCAN:
            begin
                cmd.op  = OP_SCAN;
                cmd.idx = i_reg;
            end
            S_LOAD_A:
            begin
                cmd.op  = OP_LOAD_A;
                cmd.idx = a_reg;
            end
            S_LOAD_B:
            begin
                cmd.op  = OP_LOAD_B;
                cmd.idx = b_reg;
            end
            S_PREP:      cmd.op = OP_PREP;
            S_FRAC:      cmd.op = OP_FRAC;
            S_FRAC_WAIT: if (stat.div_done) cmd.op = OP_FRAC_END;
            S_CUBE1:     cmd.op = OP_CUBE1;
            S_CUBE2:     cmd.op = OP_CUBE2;
            S_MUL:       cmd.op = OP_MUL;
            S_FINISH:    if (out_free) cmd.op = OP_RESULT;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mode_reg      <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_KEY_COUNT:   count_reg <= cfg_data;
                    REG_INTERP_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && rsp_ready && state_reg != S_FINISH)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (take && req_opcode == OPC_EVAL)
                    begin
                        n_reg <= n_clamp;
                        i_reg <= '0;
                        a_reg <= '0;
                        b_reg <= KEY_IDX_W'(n_clamp - 1'b1);
                        if (n_clamp == '0)
                        begin
                            empty_reg <= 1'b1;
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            empty_reg <= 1'b0;
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:       state_reg <= S_MOD_WAIT;
                S_MOD_WAIT:  if (stat.div_done) state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (stat.kt_le)
                        a_reg <= i_reg;
                    if (stat.kt_ge)
                    begin
                        b_reg     <= i_reg;
                        state_reg <= S_LOAD_A;
                    end
                    else if (i_reg == last_idx)
                        state_reg <= S_LOAD_A;
                    else
                        i_reg <= i_reg + 1'b1;
                end
                S_LOAD_A:    state_reg <= S_LOAD_B;
                S_LOAD_B:    state_reg <= S_PREP;
                S_PREP:      state_reg <= stat.interp_ok ? S_FRAC : S_FINISH;
                S_FRAC:      state_reg <= S_FRAC_WAIT;
                S_FRAC_WAIT:
                begin
                    if (stat.div_done)
                        state_reg <= (mode_reg == MODE_LINEAR) ? S_MUL : S_CUBE1;
                end
                S_CUBE1:     state_reg <= S_CUBE2;
                S_CUBE2:     state_reg <= S_MUL;
                S_MUL:       state_reg <= S_FINISH;
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;
    assign cfg_ready = 1'b1;
endmodule

// ===== tb/sv/tb_keyframe_curve_interpolator.sv =====
// Testbench of the keyframe curve interpolator: directed table then random beats, checked by a predictor.
`timescale 1ns / 100ps

module tb_keyframe_curve_interpolator;
    import kci_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 200;

    typedef struct {
        logic        opcode;
        logic [3:0]  key_index;
        logic [31:0] sample_time;
        logic [31:0] key_value;
        logic        check_typed;
        logic [31:0] typed_value;
        logic        typed_empty;
    } stim_row_t;

    typedef struct {
        logic [31:0] curve_value;
        logic        table_empty;
    } curve_out_t;

    logic clk;
    logic rst_n;

    kci_req_if req ();
    kci_rsp_if rsp ();
    kci_cfg_if cfg ();

    keyframe_curve_interpolator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    logic [31:0] key_time_tbl [MAX_KEYS];
    logic [31:0] key_val_tbl  [MAX_KEYS];
    logic [COUNT_W-1:0] keys_in_use;
    logic [MODE_W-1:0]  curve_mode;

    curve_out_t  pending_values [$];
    stim_row_t   directed_rows [$];
    int          fail_count;
    int          eval_count;
    int          write_count;
    int          result_count;
    int          idle_cycles;
    bit          quiet_phase;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] cube16(input logic [63:0] s);
        logic [63:0] s2;
        s2 = (s * s) >> 16;
        return (s2 * s) >> 16;
    endfunction

    function automatic curve_out_t curve_at(input logic [31:0] query);
        curve_out_t r;
        int unsigned n, lo_i, hi_i;
        logic [63:0] period, t, span, dt, frac, s, q;
        longint lo, hi, diff, acc;
        n = (keys_in_use > MAX_KEYS) ? MAX_KEYS : keys_in_use;
        if (n == 0)
        begin
            r.curve_value = '0;
            r.table_empty = 1'b1;
            return r;
        end
        lo_i = 0;
        hi_i = n - 1;
        period = {32'd0, key_time_tbl[n-1]} + 64'd65536;
        t = {32'd0, query} % period;
        for (int i = 0; i < n; i++)
        begin
            if ({32'd0, key_time_tbl[i]} <= t)
                lo_i = i;
            if ({32'd0, key_time_tbl[i]} >= t)
            begin
                hi_i = i;
                break;
            end
        end
        lo = longint'(signed'(key_val_tbl[lo_i]));
        hi = longint'(signed'(key_val_tbl[hi_i]));
        acc = lo;
        if (lo != hi && curve_mode <= MODE_CUBIC && key_time_tbl[hi_i] > key_time_tbl[lo_i]
            && t >= {32'd0, key_time_tbl[lo_i]})
        begin
            span = {32'd0, key_time_tbl[hi_i]} - {32'd0, key_time_tbl[lo_i]};
            dt = t - {32'd0, key_time_tbl[lo_i]};
            if (dt > span)
                dt = span;
            diff = hi - lo;
            if (curve_mode == MODE_LINEAR)
            begin
                frac = (dt << 16) / span;
                acc = lo + (diff * longint'(frac)) / 65536;
            end
            else
            begin
                s = (dt << 17) / span;
                if (s < 64'd65536)
                    q = cube16(s);
                else
                    q = 64'd131072 - cube16(64'd131072 - s);
                acc = lo + (diff * longint'(q)) / 131072;
            end
        end
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        r.curve_value = acc[31:0];
        r.table_empty = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic bit gap_now();
        return !quiet_phase && ($urandom_range(99) < 24);
    endfunction

    // collect results
    always @(posedge clk)
    begin
        curve_out_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                result_count++;
                if (pending_values.size() == 0)
                    report_mismatch("unexpected beat", rsp.curve_value, 32'hx);
                else
                begin
                    want = pending_values.pop_front();
                    if (rsp.curve_value !== want.curve_value)
                        report_mismatch("curve_value", rsp.curve_value, want.curve_value);
                    if (rsp.table_empty !== want.table_empty)
                        report_mismatch("table_empty", {31'd0, rsp.table_empty},
                                        {31'd0, want.table_empty});
                end
            end
            rsp.ready <= !gap_now();
        end
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $time);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_KEY_COUNT)
            keys_in_use = data;
        else
            curve_mode = data[MODE_W-1:0];
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_beat(input stim_row_t row);
        curve_out_t want;
        while (gap_now())
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.opcode      <= row.opcode;
        req.key_index   <= row.key_index;
        req.sample_time <= row.sample_time;
        req.key_value   <= row.key_value;
        do @(posedge clk); while (!req.ready);
        if (row.opcode == OPC_WRITE)
        begin
            key_time_tbl[row.key_index] = row.sample_time;
            key_val_tbl[row.key_index]  = row.key_value;
            write_count++;
        end
        else
        begin
            want = curve_at(row.sample_time);
            if (row.check_typed && (want.curve_value !== row.typed_value
                                    || want.table_empty !== row.typed_empty))
                report_mismatch("typed row", row.typed_value, want.curve_value);
            pending_values.push_back(want);
            eval_count++;
        end
    endtask

    function automatic stim_row_t mk(input logic opc, input logic [3:0] idx,
                                     input logic [31:0] t, input logic [31:0] v,
                                     input logic typed = 1'b0,
                                     input logic [31:0] tv = '0, input logic te = 1'b0);
        stim_row_t r;
        r.opcode = opc; r.key_index = idx; r.sample_time = t; r.key_value = v;
        r.check_typed = typed; r.typed_value = tv; r.typed_empty = te;
        return r;
    endfunction

    // non-decreasing table of n keys, random content
    task automatic load_keys(input int n, input bit wide);
        logic [31:0] t;
        logic [31:0] step;
        t = wide ? $urandom_range(32'h0003_0000) : $urandom_range(32'h0000_4000);
        for (int i = 0; i < n; i++)
        begin
            send_beat(mk(OPC_WRITE, i[3:0], t,
                         ($urandom_range(3) == 0) ? 32'h0001_0000 : $urandom()));
            case ($urandom_range(5))
                0: step = 0;
                1: step = $urandom_range(4);
                2: step = wide ? $urandom() >> 4 : $urandom_range(32'h0001_0000);
                default: step = $urandom_range(32'h0004_0000);
            endcase
            if (t > 32'hFFFF_FFFF - step)
                step = 0;
            t = t + step;
        end
    endtask

    initial
    begin
        logic [31:0] q;
        int          n;
        rst_n = 1'b0;
        req.valid = 1'b0; req.opcode = OPC_WRITE; req.key_index = '0;
        req.sample_time = '0; req.key_value = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0; cfg.index = REG_KEY_COUNT; cfg.data = '0;
        keys_in_use = '0; curve_mode = MODE_LINEAR;
        fail_count = 0; eval_count = 0; write_count = 0; result_count = 0;
        idle_cycles = 0; quiet_phase = 1'b0;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            key_time_tbl[i] = '0;
            key_val_tbl[i]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then five keys with extremes
        directed_rows.push_back(mk(OPC_EVAL, 0, 32'hFFFF_FFFF, 0, 1, 32'd0, 1'b1));
        directed_rows.push_back(mk(OPC_EVAL, 0, 32'h0000_0000, 0, 1, 32'd0, 1'b1));
        directed_rows.push_back(mk(OPC_WRITE, 0, 32'h0000_0000, 32'h8000_0000));
        directed_rows.push_back(mk(OPC_WRITE, 1, 32'h0001_0000, 32'h7FFF_FFFF));
        directed_rows.push_back(mk(OPC_WRITE, 2, 32'h0001_0000, 32'h0000_5000));
        directed_rows.push_back(mk(OPC_WRITE, 3, 32'h0004_0000, 32'h0000_5000));
        directed_rows.push_back(mk(OPC_WRITE, 15, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        foreach (directed_rows[i])
            send_beat(directed_rows[i]);
        directed_rows.delete();
        wait_idle();

        for (int m = 0; m < 4; m++)
        begin
            write_reg(REG_INTERP_MODE, m[4:0]);
            write_reg(REG_KEY_COUNT, 5'd4);
            directed_rows.push_back(mk(OPC_EVAL, 0, 32'h0000_0000, 0, 1, 32'h8000_0000, 1'b0));
            directed_rows.push_back(mk(OPC_EVAL, 0, 32'h0000_8000, 0));
            directed_rows.push_back(mk(OPC_EVAL, 0, 32'h0000_4000, 0));
            directed_rows.push_back(mk(OPC_EVAL, 0, 32'h0002_8000, 0, 1, 32'h0000_5000, 1'b0));
            directed_rows.push_back(mk(OPC_EVAL, 0, 32'hFFFF_FFFF, 0));
            foreach (directed_rows[i])
                send_beat(directed_rows[i]);
            directed_rows.delete();
            wait_idle();
        end
        // full table with last key at the top of the time range, and count beyond the table
        for (int i = 4; i < 15; i++)
            send_beat(mk(OPC_WRITE, i[3:0], 32'h0004_0000 + i * 32'h0100_0000, $urandom()));
        wait_idle();
        write_reg(REG_KEY_COUNT, 5'd16);
        write_reg(REG_INTERP_MODE, {3'd0, MODE_CUBIC});
        send_beat(mk(OPC_EVAL, 0, 32'hFFFF_FFFF, 0));
        send_beat(mk(OPC_EVAL, 0, 32'h8000_0000, 0));
        wait_idle();
        write_reg(REG_KEY_COUNT, 5'd31);
        send_beat(mk(OPC_EVAL, 0, 32'h7FFF_FFFF, 0));
        wait_idle();

        // random phases: load a table, then query it
        while (eval_count + write_count < 1800)
        begin
            quiet_phase = ($urandom_range(9) == 0);
            n = ($urandom_range(7) == 0) ? MAX_KEYS : $urandom_range(1, 5);
            load_keys(n, $urandom_range(1));
            wait_idle();
            write_reg(REG_KEY_COUNT, ($urandom_range(9) == 0) ? 5'd0 : n[4:0]);
            write_reg(REG_INTERP_MODE, 5'($urandom_range(3)));
            repeat ($urandom_range(8, 20))
            begin
                q = ($urandom_range(3) == 0) ? $urandom()
                  : key_time_tbl[$urandom_range(n - 1)] + $urandom_range(32'h0002_0000) - 32'h1_0000;
                if ($urandom_range(15) == 0)
                    send_beat(mk(OPC_WRITE, 4'($urandom_range(n - 1)), key_time_tbl[0],
                                 $urandom()));
                else
                    send_beat(mk(OPC_EVAL, 4'($urandom()), q, $urandom()));
            end
            wait_idle();
        end
        quiet_phase = 1'b0;
        wait_idle();

        $display("covered %0d key writes, %0d curve evaluations, %0d results checked",
                 write_count, eval_count, result_count);
        $display("modes linear, cubic, hold and unused; empty, full and over-range tables");
        if (fail_count == 0 && pending_values.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/kci_pkg.sv
rtl/kci_if.sv
rtl/kci_div.sv
rtl/kci_dp.sv
rtl/kci_ctrl.sv
rtl/keyframe_curve_interpolator.sv
tb/sv/tb_keyframe_curve_interpolator.sv
